@@ rtl/core/swm_pkg.sv @@
// Shared types for the sliding-window median filter: cell links, broadcast bundle and states.
package swm_pkg;

   // One slot of the sorted chain: occupancy flag, Q16.16 value and timestamp.
   typedef struct packed {
      logic               occ;
      logic signed [31:0] value;
      logic [31:0]        stamp;
   } entry_type;

   // What a cell hands to the cell above it (higher rank).
   typedef struct packed {
      entry_type entry;
      logic      ltd;    // entry stays in place when the oldest item is removed
      logic      s;      // post-removal entry at this rank is not above the new sample
   } lo_link_type;

   // What a cell hands to the cell below it (lower rank).
   typedef struct packed {
      entry_type   entry;
      logic        le;     // entry is occupied and not above the new sample
      logic [31:0] cand;   // timestamp travelling down towards rank zero
   } hi_link_type;

   // Signals driven to every cell at once.
   typedef struct packed {
      logic               push;
      logic               full;
      entry_type          sample;
      logic signed [31:0] old_value;
      logic signed [31:0] mid_value;
   } bcast_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_LOAD
   } state_type;

endpackage

@@ rtl/core/swm_cell.sv @@
// One rank of the sorted chain: insert/remove update and the timestamp wave towards rank zero.
module swm_cell (
   input  logic                   clock,
   input  logic                   reset,
   input  swm_pkg::bcast_type     bcast_i,
   input  swm_pkg::lo_link_type   lo_i,
   input  swm_pkg::hi_link_type   hi_i,
   output swm_pkg::lo_link_type   lo_o,
   output swm_pkg::hi_link_type   hi_o
);
   import swm_pkg::*;

   entry_type   entry_ff;
   entry_type   entry_in;
   logic [31:0] cand_ff;
   logic [31:0] cand_in;
   logic        ltd;
   logic        le;
   logic        s;
   logic        eq;
   entry_type   shift_self;
   entry_type   shift_below;

   // Before the window is full nothing is removed, so every entry stays put.
   assign ltd = !bcast_i.full || (entry_ff.value < bcast_i.old_value);
   assign le  = entry_ff.occ && (entry_ff.value <= bcast_i.sample.value);
   assign s   = ltd ? le : hi_i.le;

   // Contents of this rank and the rank below once the oldest item has gone.
   assign shift_self  = ltd ? entry_ff : hi_i.entry;
   assign shift_below = lo_i.ltd ? lo_i.entry : entry_ff;

   always_comb begin
      if (s) begin
         entry_in = shift_self;
      end else if (lo_i.s) begin
         entry_in = bcast_i.sample;
      end else begin
         entry_in = shift_below;
      end
   end

   // Equal values form one run in the chain; the lowest rank of the run is the oldest.
   assign eq      = entry_ff.occ && (entry_ff.value == bcast_i.mid_value);
   assign cand_in = eq ? entry_ff.stamp : hi_i.cand;

   // Only the occupancy flag is reset; value and timestamp are ignored while it is low.
   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff.occ <= 1'b0;
      end else if (bcast_i.push) begin
         entry_ff.occ <= entry_in.occ;
      end
      if (bcast_i.push) begin
         entry_ff.value <= entry_in.value;
         entry_ff.stamp <= entry_in.stamp;
      end
      cand_ff <= cand_in;
   end

   assign lo_o.entry = entry_ff;
   assign lo_o.ltd   = ltd;
   assign lo_o.s     = s;
   assign hi_o.entry = entry_ff;
   assign hi_o.le    = le;
   assign hi_o.cand  = cand_ff;

endmodule

@@ rtl/core/sliding_window_median_top.sv @@
// Top level of the sliding-window median filter: sorted cell chain, history line and control.
//
// Usage: samples arrive on the req_ channel (valid/ready); each accepted item carries a
// signed Q16.16 value and a 32-bit timestamp. Every item yields exactly one result item on
// the rsp_ channel. Until WINDOW samples have been taken, the result has median_valid low
// and zero value and time. Once the window is full, the result carries the median value of
// the last WINDOW samples and the timestamp of the oldest sample holding that value.
// The samples are kept in a chain of WINDOW cells sorted by value; an accepted item removes
// the oldest sample and inserts the new one as it is accepted. The timestamp of the oldest
// equal-valued entry then ripples down the chain one cell per cycle, towards rank zero.
// A new item is taken only once the result of the previous one has been loaded into the
// output register; the downward timestamp wave sets the pace.
// The result sits in an output register, so a previous result may wait for rsp_ready
// while the next item is processed; if it is still waiting when the next result is ready,
// the block holds and req_ready stays low until the receiver takes it.
// Reset (synchronous, active high) empties the window and discards any pending result.
module sliding_window_median_top #(
   parameter int WINDOW = 7
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [31:0] req_sample_value,
   input  logic [31:0] req_sample_time,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_median_valid,
   output logic [31:0] rsp_median_value,
   output logic [31:0] rsp_median_time
);
   import swm_pkg::*;

   localparam int MID    = WINDOW / 2;
   localparam int CNT_W  = (MID + 1 > 1) ? $clog2(MID + 1) : 1;
   localparam int FILL_W = $clog2(WINDOW + 1);

   localparam lo_link_type LO_EDGE = '{entry: '0, ltd: 1'b1, s: 1'b1};
   localparam hi_link_type HI_EDGE = '{entry: '0, le: 1'b0, cand: '0};

   state_type          state_ff;
   state_type          state_in;
   logic [CNT_W-1:0]   cnt_ff;
   logic [CNT_W-1:0]   cnt_in;
   logic [FILL_W-1:0]  fill_ff;
   logic [FILL_W-1:0]  fill_in;
   logic               pend_ff;
   logic               pend_in;
   logic signed [31:0] hist_ff [WINDOW];

   logic               rsp_valid_ff;
   logic               rsp_median_valid_ff;
   logic [31:0]        rsp_median_value_ff;
   logic [31:0]        rsp_median_time_ff;

   logic               push;
   logic               out_free;
   logic               load;
   logic               full;
   bcast_type          bcast;
   lo_link_type        lo_out [WINDOW];
   hi_link_type        hi_out [WINDOW];

   assign push     = req_valid && req_ready;
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign full     = (fill_ff == FILL_W'(WINDOW));

   // The last sample of the history line is the one that leaves the window on this push.
   assign bcast.push         = push;
   assign bcast.full         = full;
   assign bcast.sample.occ   = 1'b1;
   assign bcast.sample.value = req_sample_value;
   assign bcast.sample.stamp = req_sample_time;
   assign bcast.old_value    = hist_ff[WINDOW-1];
   assign bcast.mid_value    = lo_out[MID].entry.value;

   for (genvar k = 0; k < WINDOW; k++) begin : g_cell
      lo_link_type lo_in;
      hi_link_type hi_in;

      if (k == 0) begin : g_lo_edge
         assign lo_in = LO_EDGE;
      end else begin : g_lo_link
         assign lo_in = lo_out[k-1];
      end

      if (k == WINDOW - 1) begin : g_hi_edge
         assign hi_in = HI_EDGE;
      end else begin : g_hi_link
         assign hi_in = hi_out[k+1];
      end

      swm_cell u_cell (
         .clock   (clock),
         .reset   (reset),
         .bcast_i (bcast),
         .lo_i    (lo_in),
         .hi_i    (hi_in),
         .lo_o    (lo_out[k]),
         .hi_o    (hi_out[k])
      );
   end

   // History line of raw values in arrival order.
   always_ff @(posedge clock) begin
      if (push) begin
         hist_ff[0] <= req_sample_value;
         for (int k = 1; k < WINDOW; k++) begin
            hist_ff[k] <= hist_ff[k-1];
         end
      end
   end

   // Next-state logic.
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      case (state_ff)
         ST_IDLE: begin
            if (push) begin
               state_in = ST_SCAN;
               cnt_in   = CNT_W'(MID);
            end
         end
         ST_SCAN: begin
            if (cnt_ff == '0) begin
               state_in = ST_LOAD;
            end else begin
               cnt_in = cnt_ff - 1'b1;
            end
         end
         ST_LOAD: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Output logic of the sequencer.
   always_comb begin
      req_ready = 1'b0;
      load      = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
         end
         ST_LOAD: begin
            load = out_free;
         end
         default: begin
            req_ready = 1'b0;
            load      = 1'b0;
         end
      endcase
   end

   assign fill_in = (push && !full) ? fill_ff + 1'b1 : fill_ff;
   // The result is valid when the window is full after this push.
   assign pend_in = push ? (fill_ff >= FILL_W'(WINDOW - 1)) : pend_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
         fill_ff  <= '0;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         fill_ff  <= fill_in;
         pend_ff  <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // The median sits at the middle rank; its timestamp has arrived at rank zero.
   always_ff @(posedge clock) begin
      if (load) begin
         rsp_median_valid_ff <= pend_ff;
         rsp_median_value_ff <= pend_ff ? lo_out[MID].entry.value : '0;
         rsp_median_time_ff  <= pend_ff ? hi_out[0].cand : '0;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_median_valid = rsp_median_valid_ff;
   assign rsp_median_value = rsp_median_value_ff;
   assign rsp_median_time  = rsp_median_time_ff;

endmodule

@@ bench/sliding_window_median_check.sv @@
// Checker for the sliding-window median filter: predicts every result item and compares it.
`timescale 1ns / 1ps

module sliding_window_median_check #(
   parameter int WINDOW = 7
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [31:0] req_sample_value,
   input  logic [31:0] req_sample_time,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic        rsp_median_valid,
   input  logic [31:0] rsp_median_value,
   input  logic [31:0] rsp_median_time,
   output int          mismatch_count,
   output int          outstanding,
   output int          results_seen,
   output int          medians_seen
);

   typedef struct packed {
      logic               valid;
      logic signed [31:0] value;
      logic [31:0]        stamp;
   } median_result_type;

   // Own copy of the window, kept in arrival order as a ring.
   logic signed [31:0] ring_value [WINDOW];
   logic [31:0]        ring_stamp [WINDOW];
   int unsigned        next_slot;
   int unsigned        filled;
   median_result_type  median_queue [$];

   // Stores one sample and returns the median of the window that now includes it.
   // Entries are visited oldest first, so among equal values the oldest wins.
   function automatic median_result_type insert_and_median(input logic signed [31:0] value,
                                                           input logic [31:0] stamp);
      median_result_type res;
      int unsigned       idx;
      int unsigned       below;
      int unsigned       not_above;
      res = '0;
      ring_value[next_slot] = value;
      ring_stamp[next_slot] = stamp;
      next_slot = (next_slot + 1) % WINDOW;
      if (filled < WINDOW) filled++;
      if (filled < WINDOW) return res;
      for (int j = 0; j < WINDOW; j++) begin
         idx = (next_slot + j) % WINDOW;
         below = 0;
         not_above = 0;
         for (int i = 0; i < WINDOW; i++) begin
            if (ring_value[i] < ring_value[idx]) below++;
            if (ring_value[i] <= ring_value[idx]) not_above++;
         end
         if (below <= WINDOW / 2 && not_above > WINDOW / 2) begin
            res.valid = 1'b1;
            res.value = ring_value[idx];
            res.stamp = ring_stamp[idx];
            return res;
         end
      end
      return res;
   endfunction

   task automatic note_mismatch(input string what, input logic [31:0] want,
                                input logic [31:0] got);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display("%0t: %s mismatch: expected %h, got %h", $realtime, what, want, got);
   endtask

   // The result side is handled before the request side, so a result item can never
   // be matched against an expectation made in the same cycle.
   always @(posedge clock) begin : watch_channels
      median_result_type want;
      if (reset) begin
         foreach (ring_value[i]) begin
            ring_value[i] = '0;
            ring_stamp[i] = '0;
         end
         next_slot = 0;
         filled = 0;
         median_queue.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            results_seen++;
            if (median_queue.size() == 0) begin
               note_mismatch("unexpected result item", '0, rsp_median_value);
            end else begin
               want = median_queue.pop_front();
               if (rsp_median_valid === 1'b1) medians_seen++;
               if (rsp_median_valid !== want.valid)
                  note_mismatch("median_valid", {31'd0, want.valid}, {31'd0, rsp_median_valid});
               if (rsp_median_value !== want.value)
                  note_mismatch("median_value", want.value, rsp_median_value);
               if (rsp_median_time !== want.stamp)
                  note_mismatch("median_time", want.stamp, rsp_median_time);
            end
         end
         if (req_valid && req_ready)
            median_queue.push_back(insert_and_median(req_sample_value, req_sample_time));
      end
      outstanding = median_queue.size();
   end

endmodule

@@ bench/sliding_window_median_top_test.sv @@
// Testbench top for the sliding-window median filter: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module sliding_window_median_top_test;

   localparam int WINDOW       = 7;
   localparam int RANDOM_ITEMS = 1025;
   // The last stretch of the run goes without any idling on either side.
   localparam int QUIET_TAIL   = 150;
   // Cycles without any handshake before the run is declared hung. The slowest correct
   // stretch is a sender gap, the block's own processing and a receiver stall, so this
   // leaves a wide margin.
   localparam int STALL_LIMIT  = 2000;
   // Cycles allowed after the last result for a stray item to show up.
   localparam int DRAIN_CYCLES = 4 * (WINDOW / 2 + 3);

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [31:0] req_sample_value = '0;
   logic [31:0] req_sample_time = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic        rsp_median_valid;
   logic [31:0] rsp_median_value;
   logic [31:0] rsp_median_time;

   // Idling controls: quiet is shared by the sender and the receiver, sender_idle_pct is the sender's.
   logic quiet = 1'b0;
   int   sender_idle_pct = 25;

   int sent;
   int idle_cycles;
   int mismatch_count;
   int outstanding;
   int results_seen;
   int medians_seen;

   always #5 clock = ~clock;

   sliding_window_median_top #(
      .WINDOW(WINDOW)
   ) u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_sample_value(req_sample_value),
      .req_sample_time (req_sample_time),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_median_valid(rsp_median_valid),
      .rsp_median_value(rsp_median_value),
      .rsp_median_time (rsp_median_time)
   );

   sliding_window_median_check #(
      .WINDOW(WINDOW)
   ) u_check (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_sample_value(req_sample_value),
      .req_sample_time (req_sample_time),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_median_valid(rsp_median_valid),
      .rsp_median_value(rsp_median_value),
      .rsp_median_time (rsp_median_time),
      .mismatch_count  (mismatch_count),
      .outstanding     (outstanding),
      .results_seen    (results_seen),
      .medians_seen    (medians_seen)
   );

   // The receiver alternates between ready stretches and stalls.
   // At most one assignment to rsp_ready is made per clock edge, and each new
   // stretch draws its own random length, so stalls land on every phase of the
   // block's processing rhythm.
   always @(posedge clock) begin : receiver
      int hold;
      if (hold > 0) begin
         hold--;
      end else if (!reset && !quiet && $urandom_range(0, 3) == 0) begin
         rsp_ready <= 1'b0;
         hold = $urandom_range(1, 19) - 1;
      end else begin
         rsp_ready <= 1'b1;
         hold = $urandom_range(0, 25);
      end
   end

   // Watchdog: any handshake on either channel restarts the count.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("Watchdog: no item moved for %0d cycles, %0d results still due",
                  STALL_LIMIT, outstanding);
         $display("** sliding_window_median_top: FAILED **");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Offers one sample and returns at the edge where it is accepted. An optional gap, with
   // valid low, goes in front of the item; without a gap, valid simply stays high
   // from the previous item, so it is never lowered and raised in the same step.
   task automatic send_sample(input logic [31:0] value, input logic [31:0] stamp);
      int gap;
      gap = 0;
      if (!quiet && $urandom_range(0, 99) < sender_idle_pct) gap = $urandom_range(1, 19);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_sample_value <= value;
      req_sample_time  <= stamp;
      do @(posedge clock); while (!req_ready);
      sent++;
   endtask

   // Holds the sender back until every result item owed by the block has been taken.
   // The count is read at the falling edge, clear of the checker's update at the rising one.
   task automatic wait_for_drain();
      req_valid <= 1'b0;
      do @(negedge clock); while (outstanding != 0);
      @(posedge clock);
   endtask

   initial begin : stimulus
      logic [31:0] value;
      logic [31:0] stamp_cursor;

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Filling the window: extremes of both fields while the result is still not valid,
      // and the seventh sample gives the first full-window median.
      send_sample(32'h7FFF_FFFF, 32'h0000_0000);
      send_sample(32'h8000_0000, 32'hFFFF_FFFF);
      send_sample(32'h0000_0000, 32'd1);
      send_sample(32'hFFFF_FFFF, 32'd2);
      send_sample(32'h0000_0001, 32'd3);
      send_sample(32'h0001_0000, 32'd4);
      send_sample(32'hFFFF_0000, 32'd5);

      // A run of equal values: the tie must resolve to the oldest entry holding the
      // median value, which moves as the window slides.
      for (int k = 0; k < WINDOW; k++) send_sample(32'h0000_8000, 32'd100 + k);

      // Alternating most negative and most positive values, so the window holds both
      // extremes and signed ordering is exercised at the wrap point.
      for (int k = 0; k < 6; k++)
         send_sample((k % 2) ? 32'h8000_0000 : 32'h7FFF_FFFF, 32'd200 + k);

      // The largest value repeated with timestamps near the top of their range.
      for (int k = 0; k < 4; k++) send_sample(32'h7FFF_FFFF, 32'hFFFF_FFF0 + k);

      // Random part. Values are drawn partly from a tiny pool so that ties around the
      // median are frequent, partly from the extremes, and partly from the full range.
      // Timestamps mostly count upwards, with occasional fully random ones.
      stamp_cursor = $urandom();
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % 64 == 0) begin
            case ($urandom_range(0, 2))
               0:       sender_idle_pct = 0;
               1:       sender_idle_pct = 10;
               default: sender_idle_pct = 35;
            endcase
         end
         if (n == RANDOM_ITEMS - QUIET_TAIL) quiet <= 1'b1;
         if (n == RANDOM_ITEMS / 3 || n == 2 * RANDOM_ITEMS / 3) wait_for_drain();

         case ($urandom_range(0, 9))
            0, 1, 2: value = ($urandom_range(0, 4) - 2) << 16;
            3, 4: begin
               case ($urandom_range(0, 3))
                  0:       value = 32'h8000_0000;
                  1:       value = 32'h7FFF_FFFF;
                  2:       value = 32'h0000_0000;
                  default: value = 32'hFFFF_FFFF;
               endcase
            end
            default: value = $urandom();
         endcase
         if ($urandom_range(0, 7) == 0) stamp_cursor = $urandom();
         else stamp_cursor = stamp_cursor + $urandom_range(1, 50);
         send_sample(value, stamp_cursor);
      end

      // Let every result come home, then give a stray item time to show itself.
      wait_for_drain();
      repeat (DRAIN_CYCLES) @(posedge clock);
      @(negedge clock);

      $display("Run covered %0d samples and %0d result items, %0d of them full-window medians,",
               sent, results_seen, medians_seen);
      $display("with ties, signed extremes and random stalls on both channels; %0d mismatches.",
               mismatch_count);
      if (mismatch_count == 0 && outstanding == 0) begin
         $display("** sliding_window_median_top: PASSED **");
      end else begin
         $display("** sliding_window_median_top: FAILED **");
      end
      $finish;
   end

endmodule
